// ----- sv/pcg_pkg.sv -----
package pcg_pkg;

    localparam int CELLS_X      = 128;
    localparam int CELLS_Y      = 128;
    localparam int SINE_ENTRIES = 1024;

    localparam int ANGLE_W     = 16;
    localparam int STEP_W      = 16;
    localparam int COORD_W     = 7;
    localparam int COLOR_W     = 8;
    localparam int SINE_W      = 15;
    localparam int MAG_W       = 14;
    localparam int SUM_W       = 17;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam int IDX_W     = $clog2(SINE_ENTRIES);
    localparam int ROM_AW    = IDX_W - 2;
    localparam int ROM_DEPTH = SINE_ENTRIES / 4;
    localparam int QUARTER   = 16384;

    localparam logic [ANGLE_W-1:0] THIRD_TURN      = 16'd21845;
    localparam logic [ANGLE_W-1:0] TWO_THIRDS_TURN = 16'd43691;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_X_PHASE_STEP     = 3'd0,
        REG_Y_PHASE_STEP     = 3'd1,
        REG_DIAG_PHASE_STEP  = 3'd2,
        REG_TIME_STEP_FIRST  = 3'd3,
        REG_TIME_STEP_SECOND = 3'd4,
        REG_TIME_STEP_THIRD  = 3'd5
    } cfg_index_t;

    // Everything the angle stage needs from the register block.
    typedef struct packed {
        logic [STEP_W-1:0]  x_phase_step;
        logic [STEP_W-1:0]  y_phase_step;
        logic [STEP_W-1:0]  diag_phase_step;
        logic [ANGLE_W-1:0] time_phase_first;
        logic [ANGLE_W-1:0] time_phase_second;
        logic [ANGLE_W-1:0] time_phase_third;
    } angle_ctl_t;

    typedef logic [ANGLE_W-1:0] angle_trio_t [3];

    typedef logic [MAG_W-1:0] sine_rom_t [ROM_DEPTH];

    // Polynomial sine magnitude for a first-quadrant fraction f in 0..16384.
    function automatic int sine_mag(int f);
        int x2;
        int t;
        x2 = (f * f) >> 14;
        t  = 10477 - ((1142 * x2) >> 14);
        t  = 25718 - ((x2 * t) >> 14);
        return (f * t) >> 14;
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        for (int k = 0; k < ROM_DEPTH; k++)
        begin
            rom[k] = MAG_W'(sine_mag(k * (QUARTER / ROM_DEPTH)));
        end
        return rom;
    endfunction

    localparam sine_rom_t        SINE_ROM  = build_sine_rom();
    localparam logic [MAG_W-1:0] SINE_PEAK = MAG_W'(sine_mag(QUARTER));

    // Table sine in signed Q1.14. The angle is first quantized to the table grid.
    function automatic logic signed [SINE_W-1:0] sine_q14(logic [ANGLE_W-1:0] angle);
        logic [IDX_W-1:0]  idx;
        logic [1:0]        quad;
        logic [ROM_AW-1:0] k;
        logic [MAG_W-1:0]  m;
        idx  = angle[ANGLE_W-1 -: IDX_W];
        quad = idx[IDX_W-1 -: 2];
        k    = idx[ROM_AW-1:0];
        if (quad[0])
        begin
            // Falling quadrants mirror the table; the top of the curve is not stored.
            if (k == '0)
                m = SINE_PEAK;
            else
                m = SINE_ROM[ROM_AW'(~k + 1'b1)];
        end
        else
        begin
            m = SINE_ROM[k];
        end
        if (quad[1])
            return -$signed({1'b0, m});
        else
            return $signed({1'b0, m});
    endfunction

    // Maps a sine in -16384..16383 to 0..254 as ((s + 16384) * 255) >> 15.
    function automatic logic [COLOR_W-1:0] channel_level(logic signed [SINE_W-1:0] s);
        logic [SINE_W-1:0]         p;
        logic [SINE_W+COLOR_W-1:0] w;
        p = SINE_W'(s) + SINE_W'(QUARTER);
        w = {p, {COLOR_W{1'b0}}} - {{COLOR_W{1'b0}}, p};
        return w[SINE_W+COLOR_W-1 -: COLOR_W];
    endfunction

endpackage

// ----- sv/pcg_regs.sv -----
module pcg_regs
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [pcg_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [pcg_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                frame_advance,
    output pcg_pkg::angle_ctl_t                 ctl
);

    logic [pcg_pkg::STEP_W-1:0]  x_step_reg;
    logic [pcg_pkg::STEP_W-1:0]  y_step_reg;
    logic [pcg_pkg::STEP_W-1:0]  diag_step_reg;
    logic [pcg_pkg::STEP_W-1:0]  t1_step_reg;
    logic [pcg_pkg::STEP_W-1:0]  t2_step_reg;
    logic [pcg_pkg::STEP_W-1:0]  t3_step_reg;
    logic [pcg_pkg::ANGLE_W-1:0] t1_phase_reg;
    logic [pcg_pkg::ANGLE_W-1:0] t2_phase_reg;
    logic [pcg_pkg::ANGLE_W-1:0] t3_phase_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_step_reg    <= 16'd1147;
            y_step_reg    <= 16'd1356;
            diag_step_reg <= 16'd730;
            t1_step_reg   <= 16'd417;
            t2_step_reg   <= 16'd542;
            t3_step_reg   <= 16'd292;
        end
        else if (cfg_write)
        begin
            unique case (pcg_pkg::cfg_index_t'(cfg_index))
                pcg_pkg::REG_X_PHASE_STEP:     x_step_reg    <= cfg_data;
                pcg_pkg::REG_Y_PHASE_STEP:     y_step_reg    <= cfg_data;
                pcg_pkg::REG_DIAG_PHASE_STEP:  diag_step_reg <= cfg_data;
                pcg_pkg::REG_TIME_STEP_FIRST:  t1_step_reg   <= cfg_data;
                pcg_pkg::REG_TIME_STEP_SECOND: t2_step_reg   <= cfg_data;
                pcg_pkg::REG_TIME_STEP_THIRD:  t3_step_reg   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_phase_reg <= '0;
            t2_phase_reg <= '0;
            t3_phase_reg <= '0;
        end
        else if (frame_advance)
        begin
            t1_phase_reg <= t1_phase_reg + t1_step_reg;
            t2_phase_reg <= t2_phase_reg + t2_step_reg;
            t3_phase_reg <= t3_phase_reg + t3_step_reg;
        end
    end

    assign ctl.x_phase_step      = x_step_reg;
    assign ctl.y_phase_step      = y_step_reg;
    assign ctl.diag_phase_step   = diag_step_reg;
    assign ctl.time_phase_first  = t1_phase_reg;
    assign ctl.time_phase_second = t2_phase_reg;
    assign ctl.time_phase_third  = t3_phase_reg;

endmodule

// ----- sv/pcg_angle.sv -----
module pcg_angle
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            advance,
    input  logic                            in_valid,
    input  logic                            req_type,
    input  logic [pcg_pkg::COORD_W-1:0]     cell_x,
    input  logic [pcg_pkg::COORD_W-1:0]     cell_y,
    input  pcg_pkg::angle_ctl_t             ctl,
    output logic                            frame_advance,
    output logic                            angle_valid,
    output pcg_pkg::angle_trio_t            angle
);

    logic                           item_valid_reg;
    logic                           item_frame_reg;
    logic [pcg_pkg::COORD_W-1:0]    x_reg;
    logic [pcg_pkg::COORD_W-1:0]    y_reg;
    logic [pcg_pkg::COORD_W-1:0]    x_sat;
    logic [pcg_pkg::COORD_W-1:0]    y_sat;
    logic [pcg_pkg::COORD_W:0]      xy_sum;
    logic                           angle_valid_reg;
    logic                           angle_valid_next;
    pcg_pkg::angle_trio_t           angle_reg;
    pcg_pkg::angle_trio_t           angle_next;

    assign x_sat = (int'(cell_x) >= pcg_pkg::CELLS_X) ?
                   pcg_pkg::COORD_W'(pcg_pkg::CELLS_X - 1) : cell_x;
    assign y_sat = (int'(cell_y) >= pcg_pkg::CELLS_Y) ?
                   pcg_pkg::COORD_W'(pcg_pkg::CELLS_Y - 1) : cell_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg  <= 1'b0;
            angle_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            item_valid_reg  <= in_valid;
            angle_valid_reg <= angle_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            item_frame_reg <= req_type;
            x_reg          <= x_sat;
            y_reg          <= y_sat;
            angle_reg      <= angle_next;
        end
    end

    // The time phases step as a frame item leaves the input register, so a cell
    // item ahead of it still sees the old phases and one behind it the new ones.
    assign frame_advance    = advance && item_valid_reg && item_frame_reg;
    assign angle_valid_next = item_valid_reg && !item_frame_reg;

    assign xy_sum = {1'b0, x_reg} + {1'b0, y_reg};

    always_comb
    begin
        angle_next[0] = ({{(pcg_pkg::STEP_W-pcg_pkg::COORD_W){1'b0}}, x_reg}
                         * ctl.x_phase_step) + ctl.time_phase_first;
        angle_next[1] = ({{(pcg_pkg::STEP_W-pcg_pkg::COORD_W){1'b0}}, y_reg}
                         * ctl.y_phase_step) + ctl.time_phase_second;
        angle_next[2] = ({{(pcg_pkg::STEP_W-pcg_pkg::COORD_W-1){1'b0}}, xy_sum}
                         * ctl.diag_phase_step) + ctl.time_phase_third;
    end

    assign angle_valid = angle_valid_reg;
    assign angle       = angle_reg;

endmodule

// ----- sv/pcg_shade.sv -----
module pcg_shade
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            advance,
    input  logic                            angle_valid,
    input  pcg_pkg::angle_trio_t            angle,
    output logic                            out_valid,
    output logic [pcg_pkg::COLOR_W-1:0]     red,
    output logic [pcg_pkg::COLOR_W-1:0]     green,
    output logic [pcg_pkg::COLOR_W-1:0]     blue
);

    logic signed [pcg_pkg::SINE_W-1:0]  s1;
    logic signed [pcg_pkg::SINE_W-1:0]  s2;
    logic signed [pcg_pkg::SINE_W-1:0]  s3;
    logic signed [pcg_pkg::SUM_W-1:0]   v;
    logic [pcg_pkg::ANGLE_W-1:0]        base;
    logic                               out_valid_reg;
    logic [pcg_pkg::COLOR_W-1:0]        red_reg;
    logic [pcg_pkg::COLOR_W-1:0]        green_reg;
    logic [pcg_pkg::COLOR_W-1:0]        blue_reg;
    logic [pcg_pkg::COLOR_W-1:0]        red_next;
    logic [pcg_pkg::COLOR_W-1:0]        green_next;
    logic [pcg_pkg::COLOR_W-1:0]        blue_next;

    assign s1 = pcg_pkg::sine_q14(angle[0]);
    assign s2 = pcg_pkg::sine_q14(angle[1]);
    assign s3 = pcg_pkg::sine_q14(angle[2]);
    assign v  = pcg_pkg::SUM_W'(s1) + pcg_pkg::SUM_W'(s2) + pcg_pkg::SUM_W'(s3);

    // Doubling v modulo one turn keeps only its low bits.
    assign base = {v[pcg_pkg::ANGLE_W-2:0], 1'b0};

    assign red_next   = pcg_pkg::channel_level(pcg_pkg::sine_q14(base));
    assign green_next = pcg_pkg::channel_level(
                            pcg_pkg::sine_q14(base + pcg_pkg::THIRD_TURN));
    assign blue_next  = pcg_pkg::channel_level(
                            pcg_pkg::sine_q14(base + pcg_pkg::TWO_THIRDS_TURN));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= angle_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

endmodule

// ----- sv/plasma_color_generator.sv -----
// Sine plasma color generator. Each cell item (req_type 0) gives one red, green and
// blue result once it has passed the angle and result registers; a frame item (req_type 1)
// steps the three time phases and gives no result. The block is a three-register
// pipeline (input register, angle register, result register) and takes one item
// in every cycle in which in_stall is low. When a result is held by out_stall the
// whole pipeline holds, so in_stall follows out_stall combinationally while a
// result is waiting. Configuration writes take effect on the next clock edge
// and should be made while no item is in flight.
module plasma_color_generator
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [pcg_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [pcg_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                req_type,
    input  logic [pcg_pkg::COORD_W-1:0]         cell_x,
    input  logic [pcg_pkg::COORD_W-1:0]         cell_y,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [pcg_pkg::COLOR_W-1:0]         red,
    output logic [pcg_pkg::COLOR_W-1:0]         green,
    output logic [pcg_pkg::COLOR_W-1:0]         blue
);

    logic                   advance;
    logic                   frame_advance;
    logic                   angle_valid;
    pcg_pkg::angle_ctl_t    ctl;
    pcg_pkg::angle_trio_t   angle;

    assign in_stall = out_valid && out_stall;
    assign advance  = !in_stall;

    pcg_regs u_regs
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .frame_advance (frame_advance),
        .ctl           (ctl)
    );

    pcg_angle u_angle
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .in_valid      (in_valid),
        .req_type      (req_type),
        .cell_x        (cell_x),
        .cell_y        (cell_y),
        .ctl           (ctl),
        .frame_advance (frame_advance),
        .angle_valid   (angle_valid),
        .angle         (angle)
    );

    pcg_shade u_shade
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .angle_valid (angle_valid),
        .angle       (angle),
        .out_valid   (out_valid),
        .red         (red),
        .green       (green),
        .blue        (blue)
    );

endmodule
